@@ design/ptw_pkg.sv @@
`timescale 1ns / 1ps
package ptw_pkg;

  localparam int MAX_DEPTH = 8;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int VARINT_MAX = 10;

  localparam logic [1:0] KIND_FIELD = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_OVERRUN = 2'd1;
  localparam logic [1:0] ERR_VARINT  = 2'd2;
  localparam logic [1:0] ERR_DEEP    = 2'd3;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LENGTH = 3'd2;
  localparam logic [2:0] WT_FIX32  = 3'd5;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_VARINT,
    PH_FIX64,
    PH_FIX32,
    PH_LENGTH
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_CUT,
    S_POP,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [60:0]        fn;
    logic [2:0]         wt;
    logic [63:0]        val;
    logic [DEPTH_W-1:0] depth;
    logic [1:0]         err;
  } result_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic        clear;
    logic [31:0] push_end;
  } stack_ctrl_t;

endpackage

@@ design/ptw_level_stack.sv @@
`timescale 1ns / 1ps
module ptw_level_stack
  import ptw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stack_ctrl_t        ctrl_i,
  output logic [DEPTH_W-1:0] count_o,
  output logic [31:0]        top_o
);

  logic [31:0]        entry_q [MAX_DEPTH];
  logic [DEPTH_W-1:0] count_q, count_d;
  logic [IDX_W-1:0]   top_idx;
  logic [IDX_W-1:0]   push_idx;

  assign top_idx  = IDX_W'(count_q - DEPTH_W'(1));
  assign push_idx = IDX_W'(count_q);
  assign top_o    = entry_q[top_idx];
  assign count_o  = count_q;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.push) begin
      count_d = count_q + DEPTH_W'(1);
    end else if (ctrl_i.pop) begin
      count_d = count_q - DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.clear) begin
      entry_q[push_idx] <= ctrl_i.push_end;
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_W'(MAX_DEPTH))
    else $error("level count above maximum");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> count_q < DEPTH_W'(MAX_DEPTH))
    else $error("push on full stack");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> count_q != '0)
    else $error("pop on empty stack");

endmodule

@@ design/protobuf_wire_tokenizer_unit.sv @@
// Each byte passes through the states TAKE, CUT, POP (repeated once per closing nested level)
// and FLUSH, and output backpressure can stall it there; the sequencer sets this order.
// A new byte is accepted only in idle, once the previous byte has left FLUSH.
// Results leave through a one-deep hold and an output register, the last one of each byte flagged.
// Reset: asynchronous active low; clears control state, length register and level count.
`timescale 1ns / 1ps
module protobuf_wire_tokenizer_unit
  import ptw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [30:0]        message_length_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         event_kind_o,
  output logic [60:0]        field_id_o,
  output logic [2:0]         wire_code_o,
  output logic [63:0]        field_value_o,
  output logic [3:0]         nesting_depth_o,
  output logic [1:0]         error_code_o,
  output logic               last_result_o
);

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [30:0] msg_len_q;
  logic [31:0] pos_q, pos_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  vcnt_q, vcnt_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [60:0] held_fn_q, held_fn_d;
  logic [2:0]  held_wt_q, held_wt_d;
  logic        skip_q, skip_d;
  logic [31:0] skip_end_q, skip_end_d;
  logic [7:0]  byte_q;
  logic [31:0] n_q, cur_end_q;

  result_t     pend_q, emit_res;
  logic        pend_v_q;
  logic        emit_req;
  logic        out_free, stall, adv, load_out, flush_load;
  logic        in_fire, pop_hit, msg_done;
  result_t     out_q;
  logic        out_valid_q, out_last_q;

  stack_ctrl_t        sctl;
  logic [DEPTH_W-1:0] count;
  logic [31:0]        top;

  logic [63:0] acc_new;
  logic [3:0]  vcnt_inc;
  logic [6:0]  shamt;
  logic [32:0] rem;
  logic        over;
  logic        fail_req;
  logic [1:0]  fail_code;
  logic [60:0] fail_fn;
  logic [2:0]  fail_wt;
  logic [31:0] cur_end_now;

  ptw_level_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sctl),
    .count_o (count),
    .top_o   (top)
  );

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cur_end_now = (count != '0) ? top : {1'b0, msg_len_q};
  assign out_free    = !out_valid_q || out_ready_i;
  assign stall       = emit_req && pend_v_q && !out_free;
  assign adv         = !stall;
  assign pop_hit     = (count != '0) && (top == n_q);
  assign msg_done    = n_q >= {1'b0, msg_len_q};
  assign flush_load  = (state_q == S_FLUSH) && pend_v_q && out_free;
  assign load_out    = (adv && emit_req && pend_v_q) || flush_load;

  assign rem  = {1'b0, cur_end_q} - {1'b0, n_q};
  assign over = n_q > cur_end_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && msg_len_q != '0) state_d = S_TAKE;
      end
      S_TAKE:  state_d = S_CUT;
      S_CUT:   state_d = S_POP;
      S_POP: begin
        if (!pop_hit) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (!pend_v_q || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    acc_d      = acc_q;
    vcnt_d     = vcnt_q;
    fcnt_d     = fcnt_q;
    held_fn_d  = held_fn_q;
    held_wt_d  = held_wt_q;
    skip_d     = skip_q;
    skip_end_d = skip_end_q;
    emit_req   = 1'b0;
    emit_res   = '0;
    emit_res.depth = count;
    sctl       = '0;
    fail_req   = 1'b0;
    fail_code  = ERR_NONE;
    fail_fn    = held_fn_q;
    fail_wt    = held_wt_q;
    shamt      = {vcnt_q, 3'b000} - {3'b000, vcnt_q};
    acc_new    = acc_q;
    vcnt_inc   = vcnt_q + 4'd1;
    case (state_q)
      S_TAKE: begin
        if (!skip_q) begin
          case (phase_q)
            PH_TAG, PH_VARINT, PH_LENGTH: begin
              if (vcnt_q < 4'(VARINT_MAX)) begin
                acc_new = acc_q | (64'(byte_q[6:0]) << shamt[5:0]);
              end
              if (byte_q[7]) begin
                if (vcnt_inc >= 4'(VARINT_MAX)) begin
                  fail_req  = 1'b1;
                  fail_code = ERR_VARINT;
                end else begin
                  acc_d  = acc_new;
                  vcnt_d = vcnt_inc;
                end
              end else begin
                vcnt_d = '0;
                acc_d  = '0;
                case (phase_q)
                  PH_TAG: begin
                    held_fn_d = acc_new[63:3];
                    held_wt_d = acc_new[2:0];
                    fail_fn   = acc_new[63:3];
                    fail_wt   = acc_new[2:0];
                    case (acc_new[2:0])
                      WT_VARINT: phase_d = PH_VARINT;
                      WT_LENGTH: phase_d = PH_LENGTH;
                      WT_FIX64: begin
                        if (over || rem[31:0] < 32'd8) begin
                          fail_req  = 1'b1;
                          fail_code = ERR_OVERRUN;
                        end else begin
                          phase_d = PH_FIX64;
                        end
                      end
                      WT_FIX32: begin
                        if (over || rem[31:0] < 32'd4) begin
                          fail_req  = 1'b1;
                          fail_code = ERR_OVERRUN;
                        end else begin
                          phase_d = PH_FIX32;
                        end
                      end
                      default: begin
                        emit_req     = 1'b1;
                        emit_res.kind = KIND_FIELD;
                        emit_res.fn  = acc_new[63:3];
                        emit_res.wt  = acc_new[2:0];
                        phase_d      = PH_TAG;
                        fcnt_d       = '0;
                      end
                    endcase
                  end
                  PH_VARINT: begin
                    emit_req      = 1'b1;
                    emit_res.kind = KIND_FIELD;
                    emit_res.fn   = held_fn_q;
                    emit_res.wt   = held_wt_q;
                    emit_res.val  = acc_new;
                    phase_d       = PH_TAG;
                    fcnt_d        = '0;
                  end
                  default: begin
                    if (over || acc_new > {32'd0, rem[31:0]}) begin
                      fail_req  = 1'b1;
                      fail_code = ERR_OVERRUN;
                    end else if (count >= DEPTH_W'(MAX_DEPTH)) begin
                      fail_req  = 1'b1;
                      fail_code = ERR_DEEP;
                    end else begin
                      emit_req      = 1'b1;
                      emit_res.kind = KIND_FIELD;
                      emit_res.fn   = held_fn_q;
                      emit_res.wt   = held_wt_q;
                      emit_res.val  = acc_new;
                      phase_d       = PH_TAG;
                      fcnt_d        = '0;
                      sctl.push     = 1'b1;
                      sctl.push_end = n_q + acc_new[31:0];
                    end
                  end
                endcase
              end
            end
            default: begin
              acc_new = acc_q | (64'(byte_q) << {fcnt_q[2:0], 3'b000});
              acc_d   = acc_new;
              fcnt_d  = fcnt_q + 4'd1;
              if (fcnt_d >= ((phase_q == PH_FIX64) ? 4'd8 : 4'd4)) begin
                emit_req      = 1'b1;
                emit_res.kind = KIND_FIELD;
                emit_res.fn   = held_fn_q;
                emit_res.wt   = held_wt_q;
                emit_res.val  = acc_new;
                phase_d       = PH_TAG;
                acc_d         = '0;
                vcnt_d        = '0;
                fcnt_d        = '0;
              end
            end
          endcase
          if (fail_req) begin
            emit_req      = 1'b1;
            emit_res.kind = KIND_ERROR;
            emit_res.fn   = fail_fn;
            emit_res.wt   = fail_wt;
            emit_res.val  = '0;
            emit_res.err  = fail_code;
            phase_d       = PH_TAG;
            acc_d         = '0;
            vcnt_d        = '0;
            fcnt_d        = '0;
            held_fn_d     = '0;
            held_wt_d     = '0;
            skip_d        = 1'b1;
            skip_end_d    = cur_end_q;
          end
        end
      end
      S_CUT: begin
        if (!skip_q && phase_q != PH_TAG &&
            ((count != '0) ? (n_q == cur_end_q) : (n_q >= cur_end_q))) begin
          emit_req      = 1'b1;
          emit_res.kind = KIND_ERROR;
          emit_res.fn   = held_fn_q;
          emit_res.wt   = held_wt_q;
          emit_res.err  = ERR_OVERRUN;
          phase_d       = PH_TAG;
          acc_d         = '0;
          vcnt_d        = '0;
          fcnt_d        = '0;
          held_fn_d     = '0;
          held_wt_d     = '0;
        end
        if (skip_q && n_q == skip_end_q) skip_d = 1'b0;
      end
      S_POP: begin
        if (pop_hit) begin
          sctl.pop       = 1'b1;
          emit_req       = 1'b1;
          emit_res.kind  = KIND_END;
          emit_res.depth = count - DEPTH_W'(1);
          if (skip_q && n_q == skip_end_q) skip_d = 1'b0;
        end else if (msg_done) begin
          sctl.clear = 1'b1;
          pos_d      = '0;
          phase_d    = PH_TAG;
          acc_d      = '0;
          vcnt_d     = '0;
          fcnt_d     = '0;
          held_fn_d  = '0;
          held_wt_d  = '0;
          skip_d     = 1'b0;
          skip_end_d = '0;
        end else begin
          pos_d = n_q;
        end
      end
      default: begin
      end
    endcase
    if (!adv) begin
      sctl = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_TAG;
      msg_len_q   <= '0;
      pos_q       <= '0;
      acc_q       <= '0;
      vcnt_q      <= '0;
      fcnt_q      <= '0;
      held_fn_q   <= '0;
      held_wt_q   <= '0;
      skip_q      <= 1'b0;
      skip_end_q  <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) msg_len_q <= message_length_i;
      if (adv) begin
        state_q    <= state_d;
        phase_q    <= phase_d;
        pos_q      <= pos_d;
        acc_q      <= acc_d;
        vcnt_q     <= vcnt_d;
        fcnt_q     <= fcnt_d;
        held_fn_q  <= held_fn_d;
        held_wt_q  <= held_wt_d;
        skip_q     <= skip_d;
        skip_end_q <= skip_end_d;
      end
      if (adv && emit_req) begin
        pend_v_q <= 1'b1;
      end else if (flush_load) begin
        pend_v_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q    <= data_byte_i;
      n_q       <= pos_q + 32'd1;
      cur_end_q <= cur_end_now;
    end
    if (adv && emit_req) pend_q <= emit_res;
    if (load_out) begin
      out_q      <= pend_q;
      out_last_q <= flush_load;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = out_q.kind;
  assign field_id_o      = out_q.fn;
  assign wire_code_o     = out_q.wt;
  assign field_value_o   = out_q.val;
  assign nesting_depth_o = 4'(out_q.depth);
  assign error_code_o    = out_q.err;
  assign last_result_o   = out_last_q;

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_v_q)
    else $error("held result left in idle");

  a_accept_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && msg_len_q != '0) |=> state_q == S_TAKE)
    else $error("accepted byte not processed");

  a_stall_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> (pend_v_q && out_valid_q && emit_req))
    else $error("stall without pending result");

endmodule
